### hw/rtl/lcbf_pkg.sv
// Package for the line counting byte FIFO: sizes, request and status codes,
// the result record and the pointer helper functions.
// Depends on nothing; lcbf_ctrl and the top level import it.
`default_nettype none

package lcbf_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = 6;
  localparam int unsigned LINE_W = 6;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] NL_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   rd_byte;
    logic                last;
    logic [FILL_W-1:0]   fill_count;
    logic                is_empty;
    logic                is_full;
    logic [LINE_W-1:0]   line_count;
  } result_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  function automatic logic [FILL_W-1:0] fill_of(input logic [PTR_W-1:0] head,
                                                input logic [PTR_W-1:0] tail);
    logic [PTR_W:0] diff;
    if (tail >= head) begin
      diff = {1'b0, tail} - {1'b0, head};
    end else begin
      diff = {1'b0, tail} + (PTR_W+1)'(DEPTH) - {1'b0, head};
    end
    return FILL_W'(diff);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lcbf_ram.sv
// Generic single-clock RAM with one write port and one read port.
// Read data is registered and holds while no read is enabled; no dependencies.
`default_nettype none

module lcbf_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned WORDS  = 64,
  parameter int unsigned ADDR_W = $clog2(WORDS)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [WORDS];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/lcbf_ctrl.sv
// Request sequencer of the line counting byte FIFO: head and tail pointers,
// full flag, newline count and the read loop over the ring RAM.
// Depends on lcbf_pkg; drives the ports of lcbf_ram.
`default_nettype none

module lcbf_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire lcbf_pkg::kind_e             req_kind_i,
  input  wire logic [lcbf_pkg::BYTE_W-1:0] req_byte_i,
  input  wire logic                        out_free_i,
  output logic                             res_valid_o,
  output lcbf_pkg::result_t                res_o,
  output logic                             ram_we_o,
  output logic [lcbf_pkg::PTR_W-1:0]       ram_waddr_o,
  output logic [lcbf_pkg::BYTE_W-1:0]      ram_wdata_o,
  output logic                             ram_re_o,
  output logic [lcbf_pkg::PTR_W-1:0]       ram_raddr_o,
  input  wire logic [lcbf_pkg::BYTE_W-1:0] ram_rdata_i
);

  import lcbf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DATA
  } state_e;

  typedef enum logic [1:0] {
    MODE_POP,
    MODE_LINE,
    MODE_DRAIN
  } mode_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic              full_q, full_d;
  logic [LINE_W-1:0] nl_q, nl_d;

  logic              accept;
  logic [PTR_W-1:0]  tail_nxt;
  logic              fin;

  assign req_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept      = req_valid_i && req_ready_o;
  assign tail_nxt    = next_slot(tail_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    head_d      = head_q;
    tail_d      = tail_q;
    full_d      = full_q;
    nl_d        = nl_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = ST_OK;
    ram_we_o    = 1'b0;
    ram_waddr_o = tail_q;
    ram_wdata_o = req_byte_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;
    fin         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_o = 1'b1;
          res_o.last  = 1'b1;
          unique case (req_kind_i)
            KIND_PUSH: begin
              if (tail_nxt == head_q) begin
                full_d       = 1'b1;
                res_o.status = ST_FULL;
              end else begin
                ram_we_o = 1'b1;
                tail_d   = tail_nxt;
                if (next_slot(tail_nxt) == head_q) begin
                  full_d = 1'b1;
                end
                if (req_byte_i == NL_BYTE) begin
                  nl_d = nl_q + 1'b1;
                end
              end
            end
            KIND_POP: begin
              full_d = 1'b0;
              if (head_q == tail_q) begin
                res_o.status = ST_EMPTY;
              end else begin
                res_valid_o = 1'b0;
                ram_re_o    = 1'b1;
                mode_d      = MODE_POP;
                state_d     = S_DATA;
              end
            end
            KIND_LINE: begin
              if (head_q == tail_q || (!full_q && nl_q == '0)) begin
                res_o.status = ST_EMPTY;
              end else begin
                res_valid_o = 1'b0;
                ram_re_o    = 1'b1;
                mode_d      = full_q ? MODE_DRAIN : MODE_LINE;
                state_d     = S_DATA;
              end
            end
            KIND_CLEAR: begin
              head_d = '0;
              tail_d = '0;
              full_d = 1'b0;
              nl_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (out_free_i) begin
          head_d = next_slot(head_q);
          full_d = 1'b0;
          if (ram_rdata_i == NL_BYTE && nl_q != '0) begin
            nl_d = nl_q - 1'b1;
          end
          fin = (mode_q == MODE_POP) || (head_d == tail_q) ||
                (mode_q == MODE_LINE && ram_rdata_i == NL_BYTE);
          res_valid_o   = 1'b1;
          res_o.rd_byte = ram_rdata_i;
          res_o.last    = fin;
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = head_d;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.fill_count = fill_of(head_d, tail_d);
    res_o.is_empty   = (head_d == tail_d);
    res_o.is_full    = full_d;
    res_o.line_count = nl_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_POP;
      head_q  <= '0;
      tail_q  <= '0;
      full_q  <= 1'b0;
      nl_q    <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      full_q  <= full_d;
      nl_q    <= nl_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/line_counting_byte_fifo.sv
// Line counting byte FIFO. A push, clear, refused push or empty status gives its result in the
// output register in the cycle after the request; a pop or a line read passes the RAM read register
// and then the output register, and a line then streams one byte per cycle while the output is taken.
// A new request is taken once the last result is sent and the output register is free or taken.
// Reset clears the pointers, full flag and newline count at once; the ring RAM is not cleared.
`default_nettype none

module line_counting_byte_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] wr_byte
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] status, [9:2] rd_byte, [15:10] fill_count, [16] is_empty, [17] is_full,
  // [23:18] line_count
  output logic [23:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  import lcbf_pkg::*;

  logic               out_free;
  logic               res_valid;
  result_t            res;
  result_t            res_q;
  logic               m_valid_q;
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  assign out_free = !m_valid_q || m_axis_tready_i;

  lcbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_kind_i  (kind_e'(s_axis_tuser_i)),
    .req_byte_i  (s_axis_tdata_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lcbf_ram #(
    .DATA_W (BYTE_W),
    .WORDS  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tdata_o  = {res_q.line_count, res_q.is_full, res_q.is_empty,
                            res_q.fill_count, res_q.rd_byte, res_q.status};

endmodule

`default_nettype wire
